### hw/rtl/ipv4p_pkg.sv
package ipv4p_pkg;

  // Scan phase within one number of the address text.
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ZERO  = 3'd1,
    PH_XPRE  = 3'd2,
    PH_DEC   = 3'd3,
    PH_OCT   = 3'd4,
    PH_HEX   = 3'd5
  } phase_t;

  // Radix in force for the digit being added.
  typedef enum logic [1:0] {
    RADIX_8  = 2'd0,
    RADIX_10 = 2'd1,
    RADIX_16 = 2'd2
  } radix_t;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned ACC_W   = ADDR_W + 4;

  localparam logic [UNIT_W-1:0] WIDE_UNIT = 16'h007f;
  localparam logic [UNIT_W-1:0] CH_DOT    = 16'h002e;
  localparam logic [UNIT_W-1:0] CH_LOW_X  = 16'h0078;
  localparam logic [UNIT_W-1:0] CH_UP_X   = 16'h0058;

endpackage

### hw/rtl/ipv4_text_address_parser.sv
// The last code unit of a text goes through the input register, then the result register.
// Throughput: one code unit per cycle if a last unit has a free result slot; the shift-add
// and the final range check sit in one stage between the input and result registers.
// Reset (rst, synchronous, active high) empties both registers and returns the scan
// state to the start of a text; the scan state also returns there after every last unit.
module ipv4_text_address_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ipv4p_pkg::UNIT_W-1:0] s_tdata,   // [15:0] code_unit
  input  logic                         s_tlast,   // is_last
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ipv4p_pkg::ADDR_W-1:0] m_tdata,   // [31:0] address
  output logic                         m_tuser    // [0] ok
);
  import ipv4p_pkg::*;

  // Input register.
  logic              in_valid;
  logic [UNIT_W-1:0] in_code;
  logic              in_last;

  // Scan state.
  phase_t            phase, phase_next;
  logic [ADDR_W-1:0] part_value, part_value_next;
  logic              part_overflow, part_overflow_next;
  logic [1:0]        parts_done, parts_done_next;
  logic [ADDR_W-1:0] address_so_far, address_so_far_next;
  logic              failed, failed_next;

  logic              advance;
  logic              ok_calc;
  logic [ADDR_W-1:0] addr_calc;

  // Digit decode.
  logic              is_dec, is_low_hex, is_up_hex;
  logic [3:0]        digit;
  logic              add_en;
  radix_t            radix;
  logic [ACC_W-1:0]  product, acc_sum;

  // The stage moves when a result slot is free, or when the unit makes no result.
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_code <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Character classes and digit value; letters map through their low nibble.
  always_comb begin
    is_dec     = in_code inside {[16'h0030:16'h0039]};
    is_low_hex = in_code inside {[16'h0061:16'h0066]};
    is_up_hex  = in_code inside {[16'h0041:16'h0046]};
    digit      = is_dec ? in_code[3:0] : 4'(in_code[3:0] + 4'd9);
  end

  // Accumulator shift-add for the selected radix, with carry-out as overflow.
  always_comb begin
    case (radix)
      RADIX_8:  product = {1'b0, part_value, 3'b000};
      RADIX_10: product = {1'b0, part_value, 3'b000} + {3'b000, part_value, 1'b0};
      RADIX_16: product = {part_value, 4'b0000};
      default:  product = '0;
    endcase
    acc_sum = product + ACC_W'(digit);
  end

  // Next scan state for one code unit.
  always_comb begin
    phase_next          = phase;
    part_value_next     = part_value;
    part_overflow_next  = part_overflow;
    parts_done_next     = parts_done;
    address_so_far_next = address_so_far;
    failed_next         = failed;
    add_en              = 1'b0;
    radix               = RADIX_10;

    if (!failed) begin
      if (in_code >= WIDE_UNIT) begin
        failed_next = 1'b1;
      end else if (in_code == CH_DOT) begin
        if (phase == PH_START || phase == PH_XPRE || part_overflow ||
            parts_done == 2'd3 || (|part_value[ADDR_W-1:8])) begin
          failed_next = 1'b1;
        end else begin
          address_so_far_next = {address_so_far[ADDR_W-9:0], part_value[7:0]};
          parts_done_next     = 2'(parts_done + 2'd1);
          phase_next          = PH_START;
          part_value_next     = '0;
          part_overflow_next  = 1'b0;
        end
      end else begin
        case (phase)
          PH_START: begin
            if (!is_dec) begin
              failed_next = 1'b1;
            end else if (digit == 4'd0) begin
              phase_next = PH_ZERO;
            end else begin
              phase_next = PH_DEC;
              add_en     = 1'b1;
            end
          end
          PH_ZERO: begin
            radix = RADIX_8;
            if (in_code == CH_LOW_X || in_code == CH_UP_X) begin
              phase_next = PH_XPRE;
            end else if (!is_dec || digit[3]) begin
              failed_next = 1'b1;
            end else begin
              phase_next = PH_OCT;
              add_en     = 1'b1;
            end
          end
          PH_XPRE, PH_HEX: begin
            radix = RADIX_16;
            if (!(is_dec || is_low_hex || is_up_hex)) begin
              failed_next = 1'b1;
            end else begin
              phase_next = PH_HEX;
              add_en     = 1'b1;
            end
          end
          PH_DEC: begin
            if (!is_dec) begin
              failed_next = 1'b1;
            end else begin
              add_en = 1'b1;
            end
          end
          PH_OCT: begin
            radix = RADIX_8;
            if (!is_dec || digit[3]) begin
              failed_next = 1'b1;
            end else begin
              add_en = 1'b1;
            end
          end
          default: begin
            failed_next = 1'b1;
          end
        endcase
      end
    end

    if (add_en) begin
      part_value_next = acc_sum[ADDR_W-1:0];
      if (|acc_sum[ACC_W-1:ADDR_W]) begin
        part_overflow_next = 1'b1;
      end
    end
  end

  // Final check and address assembly from the state after the last unit.
  always_comb begin
    ok_calc = !failed_next && phase_next != PH_START && phase_next != PH_XPRE &&
              !part_overflow_next;
    case (parts_done_next)
      2'd0: addr_calc = part_value_next;
      2'd1: begin
        addr_calc = {address_so_far_next[7:0], part_value_next[23:0]};
        if (|part_value_next[31:24]) ok_calc = 1'b0;
      end
      2'd2: begin
        addr_calc = {address_so_far_next[15:0], part_value_next[15:0]};
        if (|part_value_next[31:16]) ok_calc = 1'b0;
      end
      2'd3: begin
        addr_calc = {address_so_far_next[23:0], part_value_next[7:0]};
        if (|part_value_next[31:8]) ok_calc = 1'b0;
      end
      default: addr_calc = '0;
    endcase
    if (!ok_calc) addr_calc = '0;
  end

  // Scan state registers; a last unit sends them back to the start of a text.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      part_value     <= '0;
      part_overflow  <= 1'b0;
      parts_done     <= 2'd0;
      address_so_far <= '0;
      failed         <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        phase          <= PH_START;
        part_value     <= '0;
        part_overflow  <= 1'b0;
        parts_done     <= 2'd0;
        address_so_far <= '0;
        failed         <= 1'b0;
      end else begin
        phase          <= phase_next;
        part_value     <= part_value_next;
        part_overflow  <= part_overflow_next;
        parts_done     <= parts_done_next;
        address_so_far <= address_so_far_next;
        failed         <= failed_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      m_tdata <= addr_calc;
      m_tuser <= ok_calc;
    end
  end

  // A last unit always produces a result item in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("last unit did not produce a result item");

  // After a last unit the scan state is back at the start of a text.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> phase == PH_START && parts_done == 2'd0 && !failed &&
    !part_overflow)
    else $error("scan state not cleared after last unit");

  // A unit that is not last never creates a result item.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    advance && !in_last && !m_tvalid |=> !m_tvalid)
    else $error("result item without a last unit");

  // A failure sticks until the end of the text.
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed && advance && !in_last |=> failed)
    else $error("failure cleared within a text");

  // A result that is not ok carries a zero address.
  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    advance && in_last && !ok_calc |=> m_tdata == '0)
    else $error("nonzero address on a failed text");

endmodule

### dv/tb_ipv4_text_address_parser.sv
`timescale 1ns / 100ps

module tb_ipv4_text_address_parser;
  import ipv4p_pkg::*;

  localparam int RUN_UNITS   = 1350;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_WAIT  = 8;

  // One code unit of address text as it travels on the input side.
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              is_last;
  } text_unit_t;

  // One parse result: ok flag and address.
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] address;
  } parse_result_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [UNIT_W-1:0] s_tdata  = '0;   // [15:0] code_unit
  logic              s_tlast  = 1'b0; // is_last
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [ADDR_W-1:0] m_tdata;         // [31:0] address
  logic              m_tuser;         // [0] ok

  text_unit_t        text_units[$];
  parse_result_t     expected_parses[$];
  logic [UNIT_W-1:0] text_buf[$];

  int   total_units    = 0;
  int   units_in       = 0;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   hold_left      = 0;
  logic hold_used      = 1'b0;
  logic in_fire        = 1'b0;

  // Scan state of the predictor.
  phase_t      scan_ph   = PH_START;
  logic [31:0] num_val   = '0;
  logic        num_ovf   = 1'b0;
  logic [1:0]  dots_seen = '0;
  logic [31:0] octets    = '0;
  logic        text_bad  = 1'b0;

  ipv4_text_address_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Digit value of a code unit in the given radix, or -1 if it is not one.
  function automatic int digit_val(logic [UNIT_W-1:0] cu, int radix);
    int d;
    d = -1;
    if (cu >= "0" && cu <= "9") d = int'(cu) - "0";
    else if (cu >= "a" && cu <= "f") d = int'(cu) - "a" + 10;
    else if (cu >= "A" && cu <= "F") d = int'(cu) - "A" + 10;
    if (d >= radix) d = -1;
    return d;
  endfunction

  task automatic clear_number();
    scan_ph = PH_START;
    num_val = '0;
    num_ovf = 1'b0;
  endtask

  // Advance the parse by one accepted code unit; on the last unit queue the result.
  task automatic parse_unit(input logic [UNIT_W-1:0] cu, input logic is_last);
    int            d;
    int            radix;
    logic [35:0]   acc;
    logic [31:0]   lim;
    parse_result_t res;
    radix = 0;
    d     = 0;
    if (!text_bad) begin
      if (cu >= WIDE_UNIT) begin
        text_bad = 1'b1;
      end else if (cu == CH_DOT) begin
        if (scan_ph == PH_START || scan_ph == PH_XPRE || num_ovf ||
            dots_seen == 2'd3 || num_val > 32'hff) begin
          text_bad = 1'b1;
        end else begin
          octets    = {octets[23:0], num_val[7:0]};
          dots_seen = dots_seen + 2'd1;
          clear_number();
        end
      end else begin
        case (scan_ph)
          PH_START: begin
            d = digit_val(cu, 10);
            if (d < 0) text_bad = 1'b1;
            else if (d == 0) scan_ph = PH_ZERO;
            else begin
              scan_ph = PH_DEC;
              radix   = 10;
            end
          end
          PH_ZERO: begin
            if (cu == CH_LOW_X || cu == CH_UP_X) begin
              scan_ph = PH_XPRE;
            end else begin
              d = digit_val(cu, 8);
              if (d < 0) text_bad = 1'b1;
              else begin
                scan_ph = PH_OCT;
                radix   = 8;
              end
            end
          end
          PH_XPRE, PH_HEX: begin
            d = digit_val(cu, 16);
            if (d < 0) text_bad = 1'b1;
            else begin
              scan_ph = PH_HEX;
              radix   = 16;
            end
          end
          PH_DEC: begin
            d = digit_val(cu, 10);
            if (d < 0) text_bad = 1'b1;
            else radix = 10;
          end
          PH_OCT: begin
            d = digit_val(cu, 8);
            if (d < 0) text_bad = 1'b1;
            else radix = 8;
          end
          default: text_bad = 1'b1;
        endcase
        // Shift-add the digit; a carry past 32 bits marks the number as too large.
        if (radix != 0) begin
          acc = {4'b0, num_val} * 36'(radix) + 36'(d);
          if (acc[35:32] != 4'b0) num_ovf = 1'b1;
          num_val = acc[31:0];
        end
      end
    end
    if (is_last) begin
      res.ok = !text_bad && scan_ph != PH_START && scan_ph != PH_XPRE && !num_ovf;
      res.address = '0;
      case (dots_seen)
        2'd0:    lim = 32'hffff_ffff;
        2'd1:    lim = 32'h00ff_ffff;
        2'd2:    lim = 32'h0000_ffff;
        default: lim = 32'h0000_00ff;
      endcase
      if (res.ok && num_val > lim) res.ok = 1'b0;
      if (res.ok) begin
        if (dots_seen == 2'd0) res.address = num_val;
        else res.address = (octets << (32 - 8 * int'(dots_seen))) | num_val;
      end
      expected_parses.push_back(res);
      clear_number();
      dots_seen = '0;
      octets    = '0;
      text_bad  = 1'b0;
    end
  endtask

  // Text building: the buffer collects one text, then moves to the send queue.
  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back({8'h00, s[i]});
  endtask

  task automatic flush_text();
    text_unit_t u;
    for (int i = 0; i < text_buf.size(); i++) begin
      u.code_unit = text_buf[i];
      u.is_last   = (i == text_buf.size() - 1);
      text_units.push_back(u);
    end
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    put_str(s);
    flush_text();
  endtask

  // Write a number as decimal (0), octal (1) or hex (2) text.
  task automatic put_number(input longint unsigned v, input int style);
    int          base;
    int          dv;
    logic        upper;
    logic [15:0] digs[$];
    upper = 1'($urandom_range(0, 1));
    base  = (style == 0) ? 10 : (style == 1) ? 8 : 16;
    if (style == 1) put_str("0");
    if (style == 2) put_str(upper ? "0X" : "0x");
    if (style == 2 && $urandom_range(0, 4) == 0) put_str("0");
    while (v != 0) begin
      dv = int'(v % base);
      digs.push_front(dv < 10 ? 16'("0") + 16'(dv)
                              : (upper ? 16'("A") : 16'("a")) + 16'(dv - 10));
      v = v / base;
    end
    if (digs.size() == 0 && style != 1) digs.push_back(16'("0"));
    foreach (digs[i]) text_buf.push_back(digs[i]);
  endtask

  // A dotted address with random radixes, mostly in range and sometimes just past it.
  task automatic put_address();
    int              nparts;
    longint unsigned lim;
    longint unsigned v;
    nparts = $urandom_range(1, 4);
    for (int p = 0; p < nparts; p++) begin
      if (p < nparts - 1) begin
        case ($urandom_range(0, 9))
          0:       v = 255;
          1:       v = 256 + $urandom_range(0, 2000);
          2:       v = $urandom_range(0, 9);
          default: v = $urandom_range(0, 255);
        endcase
      end else begin
        lim = 64'hffff_ffff >> (8 * p);
        case ($urandom_range(0, 9))
          0:       v = lim;
          1:       v = lim + 1;
          2:       v = {$urandom, $urandom} >> $urandom_range(24, 31);
          3:       v = $urandom_range(0, 9);
          default: v = longint'($urandom) & lim;
        endcase
      end
      put_number(v, $urandom_range(0, 2));
      if (p < nparts - 1) put_str(".");
    end
  endtask

  function automatic logic [15:0] noise_unit();
    string pick;
    pick = "0123456789abcdefABCDEFxX.";
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(32, 126));
      default: return {8'h00, pick[$urandom_range(0, pick.len() - 1)]};
    endcase
  endfunction

  // Directed texts, then random ones until enough code units are queued.
  initial begin
    int pos;
    send_str("0");
    send_str("4294967295");
    send_str("4294967296");
    send_str("255.255.255.255");
    send_str("1.2.3.256");
    send_str("0x");
    send_str("0XffFFffFF.1");
    send_str("0377.0x10.010");
    send_str("08");
    send_str("1..2");
    send_str(".1");
    send_str("1.");
    send_str("1.2.3.4.5");
    send_str("256.1");
    send_str("1.16777215");
    send_str("1.0x1000000");
    send_str("10.1.65535");
    send_str("99999999999.1");
    send_str(" 1");
    send_str("+0xabcdef");
    send_str("0x1g");
    // Wide and control code units, and a null unit as trailing text.
    put_str("1");
    text_buf.push_back(WIDE_UNIT);
    flush_text();
    put_str("7");
    text_buf.push_back(16'hffff);
    flush_text();
    put_str("2");
    text_buf.push_back(16'h0000);
    flush_text();
    send_str("~");

    while (text_units.size() < RUN_UNITS) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          for (int i = $urandom_range(1, 6); i > 0; i--) text_buf.push_back(noise_unit());
        end
        2, 3, 4: begin
          put_address();
          pos = $urandom_range(0, text_buf.size() - 1);
          case ($urandom_range(0, 2))
            0: text_buf[pos] = noise_unit();
            1: text_buf.insert(pos, CH_DOT);
            default: if (text_buf.size() > 1) text_buf.delete(pos);
          endcase
        end
        default: put_address();
      endcase
      flush_text();
    end
    total_units = text_units.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_units.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_parses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_parses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Idle pattern by progress: receiver-heavy gaps, then sender-heavy, then none.
  function automatic int idle_phase();
    if (units_in * 3 < total_units) return 0;
    if (units_in * 3 < total_units * 2) return 1;
    return 2;
  endfunction

  // Input driver: a held item moves on only after it was accepted.
  always @(negedge clk) begin
    int   pct;
    logic gap;
    text_unit_t u;
    pct = (idle_phase() == 0) ? 32 : (idle_phase() == 1) ? 77 : 0;
    gap = ($urandom_range(0, 99) < pct);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (text_units.size() != 0 && !gap) begin
        u = text_units.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= u.code_unit;
        s_tlast  <= u.is_last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once late in the run, with the sender still offering.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && !rst && total_units != 0 && units_in * 6 >= total_units * 5) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Result receiver stalls.
  always @(negedge clk) begin
    int pct;
    pct = (idle_phase() == 0) ? 77 : (idle_phase() == 1) ? 32 : 0;
    m_tready <= !rst && hold_left == 0 && ($urandom_range(0, 99) >= pct);
  end

  // Monitor: check each result against the oldest prediction, then predict accepted items.
  always @(posedge clk) begin
    parse_result_t exp_res;
    in_fire <= s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_parses.size() == 0) begin
          $error("result with none expected: ok %0b address %h", m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          exp_res = expected_parses.pop_front();
          if (m_tuser !== exp_res.ok) begin
            $error("ok: expected %0b, actual %0b", exp_res.ok, m_tuser);
            mismatch_count++;
          end
          if (m_tdata !== exp_res.address) begin
            $error("address: expected %h, actual %h", exp_res.address, m_tdata);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        parse_unit(s_tdata, s_tlast);
        units_in++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
